// ===== rtl/button_click_event_detector_assert.svh =====
// Assertion helpers for the button event detector.
// The including module provides clk and rst_n.
`ifndef BUTTON_CLICK_EVENT_DETECTOR_ASSERT_SVH
`define BUTTON_CLICK_EVENT_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BCED_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bced: same-cycle check failed");

// Next-cycle implication.
`define BCED_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bced: next-cycle check failed");

`else

`define BCED_ASSERT_IMP(lbl, ante, cons)
`define BCED_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/bced_pkg.sv =====
package bced_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int BTN_IDX_W   = 2;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int TICK_W      = 16;
  localparam int DEB_W       = 8;
  localparam int PRESS_W     = 8;

  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 24;

  localparam logic [TICK_W-1:0]  TICK_MAX  = '1;
  localparam logic [PRESS_W-1:0] PRESS_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_MASK = 2'd0,
    REG_DEBOUNCE    = 2'd1,
    REG_SHORT       = 2'd2,
    REG_LONG        = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_PRESSED   = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_REPRESSED = 3'd3,
    ST_LONG      = 3'd5
  } fsm_state_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_DOWN       = 3'd1,
    EV_UP         = 3'd2,
    EV_SINGLE     = 3'd3,
    EV_DOUBLE     = 3'd4,
    EV_LONG_START = 3'd5,
    EV_LONG_HOLD  = 3'd6
  } event_t;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] active_level_mask;
    logic [DEB_W-1:0]       deb_thresh;
    logic [TICK_W-1:0]      gap_limit;
    logic [TICK_W-1:0]      hold_limit;
  } cfg_t;

  typedef struct packed {
    fsm_state_t           fsm;
    logic [TICK_W-1:0]    tick_count;
    logic [DEB_W-1:0]     debounce_count;
    logic                 level;
    logic [PRESS_W-1:0]   repeat_count;
    event_t               last_event;
  } btn_state_t;

  typedef struct packed {
    logic [BTN_IDX_W-1:0] button_echo;
    event_t               held_event;
    event_t               fired_event;
    logic                 repeat_fired;
    logic [PRESS_W-1:0]   press_count;
    logic                 stable_level;
  } result_t;

endpackage

// ===== rtl/button_click_event_detector.sv =====
// Channel   Dir  Beat contents (tdata, lowest bit first)
// in_       in   button_index[1:0], pin_sample[2], zero pad to 8 bits
// out_      out  button_echo, held_event, fired_event, repeat_fired,
//                press_count, stable_level (18 bits, zero pad to 24)
// cfg_      in   write enable, register index, 16-bit write data
//
// One beat per cycle sustained while out_tready holds high; each beat passes
// the input register, then the result register, before it leaves. The per-button
// state is read and written in the same cycle the beat moves into the
// result register, so consecutive beats for one button see each other.
// A stalled result holds the result register; the input register keeps
// taking beats as long as either register has room.
// Synchronous active-low reset clears both stages and all per-button state
// and loads the config registers with their defaults.
module button_click_event_detector (
  input  logic                                clk,
  input  logic                                rst_n,
  // button_index[1:0], pin_sample[2]
  input  logic [bced_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // button_echo[1:0], held_event[4:2], fired_event[7:5], repeat_fired[8],
  // press_count[16:9], stable_level[17]
  output logic [bced_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [bced_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bced_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  bced_pkg::cfg_t                   cfg;
  bced_pkg::btn_state_t             cur_state;
  bced_pkg::btn_state_t             nxt_state;
  bced_pkg::result_t                res;

  // Input register
  logic                             s1_valid_r;
  logic                             s1_valid_nxt;
  logic [bced_pkg::BTN_IDX_W-1:0]   s1_idx_r;
  logic                             s1_pin_r;

  // Result register
  logic                             out_valid_r;
  logic                             out_valid_nxt;
  bced_pkg::result_t                out_data_r;

  logic                             s2_free;
  logic                             s1_adv;
  logic                             in_take;

  assign s2_free   = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && s2_free;
  assign in_tready = !s1_valid_r || s2_free;
  assign in_take   = in_tvalid && in_tready;

  bced_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bced_state_bank u_bank (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (s1_idx_r),
    .rd_state (cur_state),
    .wr_en    (s1_adv),
    .wr_idx   (s1_idx_r),
    .wr_state (nxt_state)
  );

  bced_step u_step (
    .cfg (cfg),
    .idx (s1_idx_r),
    .pin (s1_pin_r),
    .cur (cur_state),
    .nxt (nxt_state),
    .res (res)
  );

  // Refill the input register whenever it drains or is empty.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: load on take, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_idx_r <= in_tdata[bced_pkg::BTN_IDX_W-1:0];
      s1_pin_r <= in_tdata[bced_pkg::BTN_IDX_W];
    end
    if (s1_adv) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0,
                       out_data_r.stable_level,
                       out_data_r.press_count,
                       out_data_r.repeat_fired,
                       out_data_r.fired_event,
                       out_data_r.held_event,
                       out_data_r.button_echo};

`include "button_click_event_detector_assert.svh"

  // A fired event is always the one now held.
  `BCED_ASSERT_IMP(a_fired_is_held, out_valid_r && (out_data_r.fired_event != bced_pkg::EV_NONE), out_data_r.held_event == out_data_r.fired_event)

  // A repeat press is only ever reported as a press down.
  `BCED_ASSERT_IMP(a_repeat_is_down, out_valid_r && out_data_r.repeat_fired, out_data_r.fired_event == bced_pkg::EV_DOWN)

  // A beat parked in the input register stays there until the result side frees.
  `BCED_ASSERT_NXT(a_s1_holds, s1_valid_r && !s2_free, s1_valid_r && $stable(s1_idx_r))

  // A result blocked downstream is not overwritten by the next beat.
  `BCED_ASSERT_NXT(a_out_holds, out_valid_r && !out_tready, out_valid_r && $stable(out_data_r))

endmodule

// ===== rtl/bced_cfg_regs.sv =====
module bced_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bced_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bced_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output bced_pkg::cfg_t                    cfg
);

  bced_pkg::cfg_t cfg_r;
  bced_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (bced_pkg::cfg_reg_t'(cfg_index))
        bced_pkg::REG_ACTIVE_MASK:
          cfg_nxt.active_level_mask = cfg_wdata[bced_pkg::NUM_BUTTONS-1:0];
        bced_pkg::REG_DEBOUNCE: cfg_nxt.deb_thresh = cfg_wdata[bced_pkg::DEB_W-1:0];
        bced_pkg::REG_SHORT:    cfg_nxt.gap_limit  = cfg_wdata[bced_pkg::TICK_W-1:0];
        bced_pkg::REG_LONG:     cfg_nxt.hold_limit = cfg_wdata[bced_pkg::TICK_W-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_level_mask <= '1;
      cfg_r.deb_thresh        <= bced_pkg::DEB_W'(3);
      cfg_r.gap_limit         <= bced_pkg::TICK_W'(60);
      cfg_r.hold_limit        <= bced_pkg::TICK_W'(200);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/bced_state_bank.sv =====
module bced_state_bank (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [bced_pkg::BTN_IDX_W-1:0]    rd_idx,
  output bced_pkg::btn_state_t              rd_state,
  input  logic                              wr_en,
  input  logic [bced_pkg::BTN_IDX_W-1:0]    wr_idx,
  input  bced_pkg::btn_state_t              wr_state
);

  bced_pkg::btn_state_t state_r [bced_pkg::NUM_BUTTONS];

  // Level resets to zero: the inactive level under the reset mask of all ones.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bced_pkg::NUM_BUTTONS; i++) begin
        state_r[i].fsm            <= bced_pkg::ST_IDLE;
        state_r[i].tick_count     <= '0;
        state_r[i].debounce_count <= '0;
        state_r[i].level          <= 1'b0;
        state_r[i].repeat_count   <= '0;
        state_r[i].last_event     <= bced_pkg::EV_NONE;
      end
    end else begin
      for (int i = 0; i < bced_pkg::NUM_BUTTONS; i++) begin
        if (wr_en && (wr_idx == bced_pkg::BTN_IDX_W'(i))) begin
          state_r[i] <= wr_state;
        end
      end
    end
  end

  always_comb begin
    rd_state = state_r[0];
    for (int i = 0; i < bced_pkg::NUM_BUTTONS; i++) begin
      if (rd_idx == bced_pkg::BTN_IDX_W'(i)) begin
        rd_state = state_r[i];
      end
    end
  end

endmodule

// ===== rtl/bced_step.sv =====
module bced_step (
  input  bced_pkg::cfg_t                    cfg,
  input  logic [bced_pkg::BTN_IDX_W-1:0]    idx,
  input  logic                              pin,
  input  bced_pkg::btn_state_t              cur,
  output bced_pkg::btn_state_t              nxt,
  output bced_pkg::result_t                 res
);

  logic                           in_range;
  logic                           act;
  logic                           pressed;
  logic [bced_pkg::DEB_W-1:0]     deb_inc;
  bced_pkg::event_t               fired;
  logic                           rep;
  bced_pkg::btn_state_t           st;

  assign in_range = (int'(idx) < bced_pkg::NUM_BUTTONS);
  assign act      = cfg.active_level_mask[idx];
  assign deb_inc  = cur.debounce_count + bced_pkg::DEB_W'(1);

  always_comb begin
    st    = cur;
    fired = bced_pkg::EV_NONE;
    rep   = 1'b0;

    // Advance the gap timer while a sequence is live, hold at full scale.
    if ((cur.fsm != bced_pkg::ST_IDLE) && (cur.tick_count != bced_pkg::TICK_MAX)) begin
      st.tick_count = cur.tick_count + bced_pkg::TICK_W'(1);
    end

    // Debounce: accept a differing level after enough consecutive samples.
    if (pin != cur.level) begin
      st.debounce_count = deb_inc;
      if (deb_inc >= cfg.deb_thresh) begin
        st.level          = pin;
        st.debounce_count = '0;
      end
    end else begin
      st.debounce_count = '0;
    end

    pressed = (st.level == act);

    unique case (cur.fsm)
      bced_pkg::ST_IDLE: begin
        if (pressed) begin
          fired           = bced_pkg::EV_DOWN;
          st.tick_count   = '0;
          st.repeat_count = bced_pkg::PRESS_W'(1);
          st.fsm          = bced_pkg::ST_PRESSED;
        end else begin
          st.last_event = bced_pkg::EV_NONE;
        end
      end
      bced_pkg::ST_PRESSED: begin
        if (!pressed) begin
          fired         = bced_pkg::EV_UP;
          st.tick_count = '0;
          st.fsm        = bced_pkg::ST_RELEASED;
        end else if (st.tick_count > cfg.hold_limit) begin
          fired  = bced_pkg::EV_LONG_START;
          st.fsm = bced_pkg::ST_LONG;
        end
      end
      bced_pkg::ST_RELEASED: begin
        if (pressed) begin
          fired = bced_pkg::EV_DOWN;
          if (cur.repeat_count != bced_pkg::PRESS_MAX) begin
            st.repeat_count = cur.repeat_count + bced_pkg::PRESS_W'(1);
          end
          rep           = 1'b1;
          st.tick_count = '0;
          st.fsm        = bced_pkg::ST_REPRESSED;
        end else if (st.tick_count > cfg.gap_limit) begin
          // Three or more presses time out silently.
          if (cur.repeat_count == bced_pkg::PRESS_W'(1)) begin
            fired = bced_pkg::EV_SINGLE;
          end else if (cur.repeat_count == bced_pkg::PRESS_W'(2)) begin
            fired = bced_pkg::EV_DOUBLE;
          end
          st.fsm = bced_pkg::ST_IDLE;
        end
      end
      bced_pkg::ST_REPRESSED: begin
        if (!pressed) begin
          fired = bced_pkg::EV_UP;
          if (st.tick_count < cfg.gap_limit) begin
            st.tick_count = '0;
            st.fsm        = bced_pkg::ST_RELEASED;
          end else begin
            st.fsm = bced_pkg::ST_IDLE;
          end
        end else if (st.tick_count > cfg.gap_limit) begin
          st.fsm = bced_pkg::ST_IDLE;
        end
      end
      bced_pkg::ST_LONG: begin
        if (pressed) begin
          fired = bced_pkg::EV_LONG_HOLD;
        end else begin
          fired  = bced_pkg::EV_UP;
          st.fsm = bced_pkg::ST_IDLE;
        end
      end
      default: begin
        st.fsm = bced_pkg::ST_IDLE;
      end
    endcase

    if (fired != bced_pkg::EV_NONE) begin
      st.last_event = fired;
    end
  end

  always_comb begin
    res.button_echo = idx;
    if (in_range) begin
      nxt              = st;
      res.held_event   = st.last_event;
      res.fired_event  = fired;
      res.repeat_fired = rep;
      res.press_count  = st.repeat_count;
      res.stable_level = st.level;
    end else begin
      nxt              = cur;
      res.held_event   = bced_pkg::EV_NONE;
      res.fired_event  = bced_pkg::EV_NONE;
      res.repeat_fired = 1'b0;
      res.press_count  = '0;
      res.stable_level = 1'b0;
    end
  end

endmodule
